// ===== design/ila_pkg.sv =====
package ila_pkg;

   localparam int unsigned POS_WIDTH   = 32;
   localparam int unsigned LWID_WIDTH  = 21;
   localparam int unsigned TAG_WIDTH   = 16;
   localparam int unsigned LANE_OUT_W  = 4;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_LINE_START = 1'b0,
      CSR_LINE_WIDTH       = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_PLACED   = 3'd0,
      STATUS_SKIPPED  = 3'd1,
      STATUS_DEFERRED = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_REPORT   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SHADE_EMPTY  = 2'd0,
      SHADE_ACTIVE = 2'd1,
      SHADE_ENDED  = 2'd2
   } shade_type;

   typedef struct packed {
      logic                 req_type;
      logic [POS_WIDTH-1:0] start_pos;
      logic [POS_WIDTH-1:0] stop_pos;
      logic [TAG_WIDTH-1:0] annotation_id;
   } req_item_type;

   typedef struct packed {
      status_type            status;
      logic [LANE_OUT_W-1:0] lane;
      logic [TAG_WIDTH-1:0]  lane_tag;
      shade_type             shade;
      logic                  last;
   } rsp_item_type;

endpackage

// ===== design/interval_lane_allocator_core.sv =====
// Packs start-sorted intervals into display lanes one row at a time. Raise start
// while busy is low to transfer a request; every result shows for exactly one
// cycle with rsp_valid high and cannot be held off, and rsp_data.last marks the
// final result of a request. An offer passes through the load and decide states, and
// its one result is registered from the decide state. A row advance passes through
// the load and prep states and then stays in the report state for one lane report per
// lane in use, since the lane tag and end memories are read over their one read port,
// one lane a cycle and one lane ahead of the report, while each lane is reported and
// aged. No memory clearing runs after reset. Write csr_* only while busy is low and no
// result is still pending.
module interval_lane_allocator_core #(
   parameter int unsigned LANE_COUNT = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  ila_pkg::req_item_type               req_data,
   output logic                                rsp_valid,
   output ila_pkg::rsp_item_type               rsp_data,
   input  logic                                csr_we,
   input  logic [ila_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ila_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned LW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
   localparam int unsigned UW = $clog2(LANE_COUNT + 1);
   localparam int unsigned EW = (LW > ila_pkg::LANE_OUT_W) ? LW : ila_pkg::LANE_OUT_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOAD   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_PREP   = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   ila_pkg::req_item_type              req_ff, req_in;
   logic [ila_pkg::POS_WIDTH-1:0]      first_ff, first_in;
   logic [ila_pkg::LWID_WIDTH-1:0]     width_ff, width_in;
   logic [ila_pkg::POS_WIDTH-1:0]      row_offset_ff, row_offset_in;
   logic [ila_pkg::POS_WIDTH-1:0]      line_start_ff, line_start_in;
   logic [ila_pkg::POS_WIDTH-1:0]      next_start_ff, next_start_in;
   logic [UW-1:0]                      used_ff, used_in;
   logic [LW-1:0]                      idx_ff, idx_in;
   ila_pkg::shade_type                 cond_ff [LANE_COUNT];
   ila_pkg::shade_type                 cond_in [LANE_COUNT];
   logic                               rsp_valid_ff, rsp_valid_in;
   ila_pkg::rsp_item_type              rsp_ff, rsp_in;

   logic [ila_pkg::TAG_WIDTH-1:0]      lane_tag_mem [LANE_COUNT];
   logic [ila_pkg::POS_WIDTH-1:0]      lane_end_mem [LANE_COUNT];
   logic [ila_pkg::TAG_WIDTH-1:0]      tag_rd_ff;
   logic [ila_pkg::POS_WIDTH-1:0]      end_rd_ff;
   logic [LW-1:0]                      rd_addr;
   logic                               mem_we;

   logic                               accept;
   logic                               skip;
   logic                               defer;
   logic [ila_pkg::POS_WIDTH:0]        row_limit;
   logic                               found;
   logic [LW-1:0]                      free_slot;
   logic [LW-1:0]                      slot;
   logic                               full;
   logic [EW-1:0]                      slot_ext;
   logic [EW-1:0]                      idx_ext;
   logic                               report_last;
   ila_pkg::shade_type                 cur_shade;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign row_limit = {1'b0, line_start_ff} + (ila_pkg::POS_WIDTH + 1)'(width_ff);
   assign skip      = req_ff.stop_pos < line_start_ff;
   assign defer     = {1'b0, req_ff.start_pos} > row_limit;

   always_comb begin
      found     = 1'b0;
      free_slot = '0;
      for (int k = 0; k < LANE_COUNT; k++) begin
         if (!found && (UW'(k) < used_ff) && (cond_ff[k] == ila_pkg::SHADE_EMPTY)) begin
            found     = 1'b1;
            free_slot = LW'(k);
         end
      end
   end

   assign full        = !found && (used_ff == UW'(LANE_COUNT));
   assign slot        = found ? free_slot : used_ff[LW-1:0];
   assign slot_ext    = EW'(slot);
   assign idx_ext     = EW'(idx_ff);
   assign report_last = (UW'(idx_ff) + UW'(1)) == used_ff;
   assign cur_shade   = cond_ff[idx_ff];
   assign mem_we      = (state_ff == ST_DECIDE) && !skip && !defer && !full;
   assign rd_addr     = (state_ff == ST_REPORT) ? idx_ff + LW'(1) : '0;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      first_in      = first_ff;
      width_in      = width_ff;
      row_offset_in = row_offset_ff;
      line_start_in = line_start_ff;
      next_start_in = next_start_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      cond_in       = cond_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;

      if (csr_we) begin
         unique case (ila_pkg::csr_index_type'(csr_index))
            ila_pkg::CSR_FIRST_LINE_START: first_in = csr_wdata;
            ila_pkg::CSR_LINE_WIDTH:       width_in = csr_wdata[ila_pkg::LWID_WIDTH-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            line_start_in = first_ff + row_offset_ff;
            state_in      = req_ff.req_type ? ST_PREP : ST_DECIDE;
         end
         ST_DECIDE: begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            priority if (skip) begin
               rsp_in.status = ila_pkg::STATUS_SKIPPED;
            end else if (defer) begin
               rsp_in.status = ila_pkg::STATUS_DEFERRED;
            end else if (full) begin
               rsp_in.status = ila_pkg::STATUS_FULL;
            end else begin
               rsp_in.status   = ila_pkg::STATUS_PLACED;
               rsp_in.lane     = slot_ext[ila_pkg::LANE_OUT_W-1:0];
               rsp_in.lane_tag = req_ff.annotation_id;
               rsp_in.shade    = ila_pkg::SHADE_ACTIVE;
               cond_in[slot]   = ila_pkg::SHADE_ACTIVE;
               if (!found) begin
                  used_in = used_ff + UW'(1);
               end
            end
            state_in = ST_IDLE;
         end
         ST_PREP: begin
            row_offset_in = row_offset_ff + ila_pkg::POS_WIDTH'(width_ff);
            next_start_in = line_start_ff + ila_pkg::POS_WIDTH'(width_ff);
            idx_in        = '0;
            state_in      = ST_REPORT;
         end
         ST_REPORT: begin
            rsp_valid_in    = 1'b1;
            rsp_in.status   = ila_pkg::STATUS_REPORT;
            rsp_in.lane     = idx_ext[ila_pkg::LANE_OUT_W-1:0];
            rsp_in.lane_tag = (cur_shade == ila_pkg::SHADE_EMPTY) ? '0 : tag_rd_ff;
            rsp_in.shade    = cur_shade;
            rsp_in.last     = report_last;
            unique case (cur_shade)
               ila_pkg::SHADE_ENDED: cond_in[idx_ff] = ila_pkg::SHADE_EMPTY;
               ila_pkg::SHADE_ACTIVE: begin
                  if (end_rd_ff < next_start_ff) begin
                     cond_in[idx_ff] = ila_pkg::SHADE_ENDED;
                  end
               end
               default: ;
            endcase
            if (report_last) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + LW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_ff      <= '0;
         width_ff      <= ila_pkg::LWID_WIDTH'(1);
         row_offset_ff <= '0;
         used_ff       <= UW'(1);
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < LANE_COUNT; k++) begin
            cond_ff[k] <= ila_pkg::SHADE_EMPTY;
         end
      end else begin
         state_ff      <= state_in;
         first_ff      <= first_in;
         width_ff      <= width_in;
         row_offset_ff <= row_offset_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         cond_ff       <= cond_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      line_start_ff <= line_start_in;
      next_start_ff <= next_start_in;
      idx_ff        <= idx_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lane_tag_mem[slot] <= req_ff.annotation_id;
         lane_end_mem[slot] <= req_ff.stop_pos;
      end
      tag_rd_ff <= lane_tag_mem[rd_addr];
      end_rd_ff <= lane_end_mem[rd_addr];
   end

endmodule

// ===== design/ila_checker.sv =====
module ila_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input ila_pkg::rsp_item_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transfer taken but block not busy");

   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work in flight");

   a_offer_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ila_pkg::STATUS_REPORT) |-> rsp_data.last)
      else $error("offer result not marked last");

   a_unplaced_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ila_pkg::STATUS_REPORT)
         && (rsp_data.status != ila_pkg::STATUS_PLACED)
      |-> (rsp_data.lane == '0) && (rsp_data.lane_tag == '0)
         && (rsp_data.shade == ila_pkg::SHADE_EMPTY))
      else $error("unplaced offer carries lane data");

   a_empty_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ila_pkg::STATUS_REPORT)
         && (rsp_data.shade == ila_pkg::SHADE_EMPTY)
      |-> (rsp_data.lane_tag == '0))
      else $error("empty lane reported with tag");

endmodule

bind interval_lane_allocator_core ila_checker u_ila_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb_interval_lane_allocator_core.sv =====
`timescale 1ns / 1ps

module tb_interval_lane_allocator_core;

   localparam int LANES = 16;
   localparam int STALL_LIMIT = 2000;
   localparam logic REQ_OFFER = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   ila_pkg::req_item_type req_data = '0;
   logic rsp_valid;
   ila_pkg::rsp_item_type rsp_data;
   logic csr_we = 1'b0;
   logic [ila_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ila_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   interval_lane_allocator_core #(
      .LANE_COUNT(LANES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   logic [31:0] cfg_first_start = '0;
   logic [20:0] cfg_line_width = 21'd1;
   logic [15:0] lane_tag_m [LANES] = '{default: '0};
   logic [31:0] lane_end_m [LANES] = '{default: '0};
   ila_pkg::shade_type lane_shade_m [LANES] = '{default: ila_pkg::SHADE_EMPTY};
   int lanes_used = 1;
   logic [31:0] row_off = '0;

   ila_pkg::req_item_type pending_reqs [$];
   ila_pkg::rsp_item_type lane_results_due [$];
   int sender_idle_pct = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;

   function automatic void predict_lanes(ila_pkg::req_item_type r);
      ila_pkg::rsp_item_type res;
      logic [31:0] ls;
      logic [32:0] le;
      int slot;
      ls = cfg_first_start + row_off;
      le = {1'b0, ls} + 33'(cfg_line_width);
      res = '0;
      res.last = 1'b1;
      if (r.req_type == REQ_OFFER) begin
         slot = -1;
         if (r.stop_pos < ls) begin
            res.status = ila_pkg::STATUS_SKIPPED;
         end else if ({1'b0, r.start_pos} > le) begin
            res.status = ila_pkg::STATUS_DEFERRED;
         end else begin
            for (int k = 0; k < lanes_used; k++) begin
               if (slot < 0 && lane_shade_m[k] == ila_pkg::SHADE_EMPTY) slot = k;
            end
            if (slot < 0 && lanes_used < LANES) begin
               slot = lanes_used;
               lanes_used++;
            end
            if (slot < 0) begin
               res.status = ila_pkg::STATUS_FULL;
            end else begin
               lane_tag_m[slot] = r.annotation_id;
               lane_end_m[slot] = r.stop_pos;
               lane_shade_m[slot] = ila_pkg::SHADE_ACTIVE;
               res.status = ila_pkg::STATUS_PLACED;
               res.lane = slot[3:0];
               res.lane_tag = r.annotation_id;
               res.shade = ila_pkg::SHADE_ACTIVE;
            end
         end
         lane_results_due = {lane_results_due, res};
      end else begin
         for (int k = 0; k < lanes_used; k++) begin
            res.status = ila_pkg::STATUS_REPORT;
            res.lane = k[3:0];
            res.lane_tag = lane_tag_m[k];
            res.shade = lane_shade_m[k];
            res.last = (k == lanes_used - 1);
            lane_results_due = {lane_results_due, res};
         end
         row_off = row_off + 32'(cfg_line_width);
         ls = cfg_first_start + row_off;
         for (int k = 0; k < LANES; k++) begin
            if (lane_shade_m[k] == ila_pkg::SHADE_ENDED) begin
               lane_shade_m[k] = ila_pkg::SHADE_EMPTY;
               lane_tag_m[k] = '0;
               lane_end_m[k] = '0;
            end else if (lane_shade_m[k] == ila_pkg::SHADE_ACTIVE && lane_end_m[k] < ls) begin
               lane_shade_m[k] = ila_pkg::SHADE_ENDED;
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      logic took;
      took = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_lanes(req_data);
            void'(pending_reqs.pop_front());
            took = 1'b1;
         end
         if (!(start && !took)) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               start <= 1'b1;
               req_data <= pending_reqs[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      ila_pkg::rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (lane_results_due.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result: status=%0d lane=%0d tag=%h shade=%0d last=%0d",
                        rsp_data.status, rsp_data.lane, rsp_data.lane_tag,
                        rsp_data.shade, rsp_data.last);
            mismatch_count++;
         end else begin
            want = lane_results_due.pop_front();
            if (rsp_data.status !== want.status || rsp_data.lane !== want.lane ||
                rsp_data.lane_tag !== want.lane_tag || rsp_data.shade !== want.shade ||
                rsp_data.last !== want.last) begin
               if (mismatch_count < 10) begin
                  $display("result mismatch: expected status=%0d lane=%0d tag=%h shade=%0d last=%0d",
                           want.status, want.lane, want.lane_tag, want.shade, want.last);
                  $display("                 actual   status=%0d lane=%0d tag=%h shade=%0d last=%0d",
                           rsp_data.status, rsp_data.lane, rsp_data.lane_tag,
                           rsp_data.shade, rsp_data.last);
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic program_register(ila_pkg::csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ila_pkg::CSR_FIRST_LINE_START: cfg_first_start = val;
         ila_pkg::CSR_LINE_WIDTH: cfg_line_width = val[20:0];
         default: ;
      endcase
   endtask

   function automatic void queue_req(logic kind, logic [31:0] s, logic [31:0] e,
                                     logic [15:0] tag);
      ila_pkg::req_item_type r;
      r.req_type = kind;
      r.start_pos = s;
      r.stop_pos = e;
      r.annotation_id = tag;
      pending_reqs = {pending_reqs, r};
   endfunction

   task automatic settle_lanes();
      while (pending_reqs.size() != 0 || lane_results_due.size() != 0 || start || busy)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic run_phase(logic [31:0] first, logic [20:0] width, int idle_pct,
                            int n_items);
      logic [31:0] ls, s, e, len, w;
      int left, offers, pick;
      program_register(ila_pkg::CSR_FIRST_LINE_START, first);
      program_register(ila_pkg::CSR_LINE_WIDTH, {11'b0, width});
      @(negedge clock);
      sender_idle_pct = idle_pct;
      ls = cfg_first_start + row_off;
      w = 32'(cfg_line_width);
      left = n_items;
      while (left > 0) begin
         offers = $urandom_range(0, 5);
         for (int i = 0; i < offers && left > 1; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               if ($urandom_range(0, 99) < 15) s = ls - $urandom_range(0, 3 * w + 3);
               else s = ls + $urandom_range(0, w);
               pick = $urandom_range(0, 9);
               if (pick < 6) len = $urandom_range(0, 2 * w + 2);
               else if (pick < 9) len = $urandom_range(0, 8 * w + 8);
               else len = $urandom;
               e = s + len;
            end else if (pick < 80) begin
               e = ls - 1 - $urandom_range(0, w);
               s = e - $urandom_range(0, 100);
            end else if (pick < 90) begin
               s = ls + w + 1 + $urandom_range(0, 1000);
               e = s + $urandom_range(0, 1000);
            end else begin
               s = $urandom;
               e = $urandom;
            end
            queue_req(REQ_OFFER, s, e, 16'($urandom));
            left--;
         end
         queue_req(REQ_ADVANCE, $urandom, $urandom, 16'($urandom));
         left--;
         ls = ls + w;
      end
      settle_lanes();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      program_register(ila_pkg::CSR_FIRST_LINE_START, 32'd100);
      program_register(ila_pkg::CSR_LINE_WIDTH, 32'd10);
      @(negedge clock);
      // row 100..110 with nothing placed, then row 110..120
      queue_req(REQ_ADVANCE, '0, '0, '0);
      queue_req(REQ_OFFER, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
      queue_req(REQ_OFFER, 32'd0, 32'd0, 16'h1234);
      queue_req(REQ_OFFER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h5555);
      queue_req(REQ_OFFER, 32'd120, 32'd120, 16'h0F0F);
      queue_req(REQ_OFFER, 32'd115, 32'd115, 16'h0000);
      queue_req(REQ_ADVANCE, '1, '1, '1);
      queue_req(REQ_ADVANCE, '0, '0, '0);
      queue_req(REQ_OFFER, 32'd130, 32'd140, 16'hAAAA);
      for (int i = 0; i < 14; i++)
         queue_req(REQ_OFFER, 32'd130 + i, 32'd150, 16'(16'h0100 + i));
      queue_req(REQ_ADVANCE, '0, '0, '0);
      settle_lanes();
      run_phase(32'h0, 21'd1, 0, 90);
      run_phase(32'hFFFF_FFFF, 21'h10_0000, 79, 90);
      run_phase($urandom, 21'd0, 0, 90);
      run_phase($urandom, 21'($urandom_range(1, 32'h10_0000)), 34, 90);
      repeat (24) @(negedge clock);
      if (mismatch_count == 0 && lane_results_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
